>>> src/life_generation_stream_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef LIFE_GENERATION_STREAM_MACROS_SVH
`define LIFE_GENERATION_STREAM_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define LGS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define LGS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LGS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define LGS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> src/lgs_pkg.sv
`timescale 1ns / 1ps
package lgs_pkg;

    localparam int DEF_MAX_ROWS = 1024;
    localparam int DEF_MAX_COLS = 1024;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int POS_W        = 10;
    localparam int DIM_RESET    = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef logic [2:0][2:0] lgs_win_t;

    typedef struct packed {
        logic       clear;
        logic       shift;
        logic [2:0] col_in;   // [0] upper line, [1] middle line, [2] arriving cell
    } lgs_win_ctrl_t;

    function automatic int clamp_dim(input int v, input int hi);
        int r;
        r = v;
        if (v < 3) r = 3;
        else if (v > hi) r = hi;
        return r;
    endfunction

    // B3/S23 rule on a 3x3 window, centre at [1][1]
    function automatic logic life_rule(input lgs_win_t w);
        int n;
        logic res;
        n = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (!(i == 1 && j == 1)) n = n + int'(w[i][j]);
            end
        end
        if (w[1][1]) res = (n == 2) || (n == 3);
        else res = (n == 3);
        return res;
    endfunction

endpackage

>>> src/lgs_line_store.sv
`timescale 1ns / 1ps
module lgs_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [1:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [1:0]               rd_data
);
    // bit 1: upper line, bit 0: middle line
    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/lgs_window.sv
`timescale 1ns / 1ps
module lgs_window (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lgs_pkg::lgs_win_ctrl_t ctrl,
    output logic                  rule_alive
);
    import lgs_pkg::*;

    lgs_win_t win_reg;
    lgs_win_t win_next;

    always_comb begin
        win_next = win_reg;
        if (ctrl.clear) begin
            win_next = '0;
        end else if (ctrl.shift) begin
            for (int i = 0; i < 3; i++) begin
                win_next[i][0] = win_reg[i][1];
                win_next[i][1] = win_reg[i][2];
                win_next[i][2] = ctrl.col_in[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else begin
            win_reg <= win_next;
        end
    end

    assign rule_alive = life_rule(win_next);

endmodule

>>> src/life_generation_stream.sv
`timescale 1ns / 1ps
`include "life_generation_stream_macros.svh"
// One Game of Life generation step (B3/S23) on a raster cell stream. Cells enter one per beat
// on s_ (tuser 0 = cell, 1 = flush) and leave in raster order grid_cols + 1 cells behind, each
// with its row, column and a tlast on the final cell of the frame; first and last rows and
// columns always come out dead, and flush beats drain the tail. One beat per cycle is taken
// and given while m_tready is high: the two line stores share one memory with a single read
// and a single write port, read as a beat is taken and written when the stage-1 register
// hands that beat to the result register. The line stores have no clearing pass; their unwritten
// entries only feed border cells. Writing grid_rows or grid_cols restarts the stream.
module life_generation_stream #(
    parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [0] cell_alive
    input  logic                         s_tuser,   // [0] kind
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,   // [0] next_alive, [10:1] out_row, [20:11] out_col
    output logic                         m_tlast,   // last_of_frame
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]    cfg_data
);
    import lgs_pkg::*;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int DIMR_W = $clog2(MAX_ROWS + 1);
    localparam int DIMC_W = $clog2(MAX_COLS + 1);
    localparam int PEND_W = $clog2(MAX_COLS + 2);
    localparam logic [DIMR_W-1:0] ROWS_RST = DIMR_W'(clamp_dim(DIM_RESET, MAX_ROWS));
    localparam logic [DIMC_W-1:0] COLS_RST = DIMC_W'(clamp_dim(DIM_RESET, MAX_COLS));

    logic [DIMR_W-1:0] rows_reg, rows_next;
    logic [DIMC_W-1:0] cols_reg, cols_next;
    logic              restart;

    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic              v1_reg, v1_next;
    logic              kind1_reg;
    logic              cell1_reg;
    logic [COL_W-1:0]  col1_reg;

    logic [PEND_W-1:0] pending_reg, pending_next;
    logic [ROW_W-1:0]  emit_row_reg, emit_row_next;
    logic [COL_W-1:0]  emit_col_reg, emit_col_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_alive_reg, m_alive_next;
    logic [POS_W-1:0]  m_row_reg, m_row_next;
    logic [POS_W-1:0]  m_col_reg, m_col_next;
    logic              m_last_reg, m_last_next;

    logic              accept, adv1, proc, emit;
    logic [PEND_W-1:0] cols_plus1;
    logic [1:0]        rd_data;
    logic              mem_wr;
    logic              rule_alive;
    logic              interior, is_last_row, is_last_col;
    lgs_win_ctrl_t     win_ctrl;

    // configuration
    assign cfg_ready = 1'b1;

    always_comb begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        restart   = 1'b0;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_GRID_ROWS: begin
                    rows_next = DIMR_W'(clamp_dim(int'(cfg_data), MAX_ROWS));
                    restart   = 1'b1;
                end
                REG_GRID_COLS: begin
                    cols_next = DIMC_W'(clamp_dim(int'(cfg_data), MAX_COLS));
                    restart   = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // handshake
    assign adv1     = !m_valid_reg || m_tready;
    assign s_tready = !v1_reg || adv1;
    assign accept   = s_tvalid && s_tready;
    assign proc     = v1_reg && adv1;

    assign cols_plus1 = PEND_W'(cols_reg) + PEND_W'(1);

    lgs_line_store #(
        .DEPTH(MAX_COLS)
    ) u_line_store (
        .aclk   (aclk),
        .wr_en  (mem_wr),
        .wr_addr(col1_reg),
        .wr_data({rd_data[0], cell1_reg}),
        .rd_en  (accept),
        .rd_addr(in_col_reg),
        .rd_data(rd_data)
    );

    assign mem_wr = proc && (kind1_reg == KIND_CELL);

    always_comb begin
        win_ctrl.clear  = restart;
        win_ctrl.shift  = mem_wr;
        win_ctrl.col_in = {cell1_reg, rd_data[0], rd_data[1]};
    end

    lgs_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (win_ctrl),
        .rule_alive(rule_alive)
    );

    // input column counter
    always_comb begin
        in_col_next = in_col_reg;
        if (accept && (s_tuser == KIND_CELL)) begin
            if ((DIMC_W'(in_col_reg) + DIMC_W'(1)) >= cols_reg) in_col_next = '0;
            else in_col_next = in_col_reg + COL_W'(1);
        end
    end

    always_comb begin
        v1_next = v1_reg;
        if (accept) v1_next = 1'b1;
        else if (proc) v1_next = 1'b0;
    end

    // pending count and emit decision
    always_comb begin
        pending_next = pending_reg;
        emit         = 1'b0;
        if (proc) begin
            if (kind1_reg == KIND_FLUSH) begin
                if (pending_reg != '0) begin
                    pending_next = pending_reg - PEND_W'(1);
                    emit         = 1'b1;
                end
            end else if (pending_reg >= cols_plus1) begin
                emit = 1'b1;
            end else begin
                pending_next = pending_reg + PEND_W'(1);
            end
        end
    end

    assign is_last_row = (DIMR_W'(emit_row_reg) + DIMR_W'(1)) == rows_reg;
    assign is_last_col = (DIMC_W'(emit_col_reg) + DIMC_W'(1)) == cols_reg;
    assign interior    = (emit_row_reg != '0) && !is_last_row &&
                         (emit_col_reg != '0) && !is_last_col;

    // emit position
    always_comb begin
        emit_row_next = emit_row_reg;
        emit_col_next = emit_col_reg;
        if (emit) begin
            if (is_last_col) begin
                emit_col_next = '0;
                if (is_last_row) emit_row_next = '0;
                else emit_row_next = emit_row_reg + ROW_W'(1);
            end else begin
                emit_col_next = emit_col_reg + COL_W'(1);
            end
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_alive_next = m_alive_reg;
        m_row_next   = m_row_reg;
        m_col_next   = m_col_reg;
        m_last_next  = m_last_reg;
        if (proc) begin
            m_valid_next = emit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_alive_next = interior && rule_alive;
            m_row_next   = POS_W'(emit_row_reg);
            m_col_next   = POS_W'(emit_col_reg);
            m_last_next  = is_last_row && is_last_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg     <= ROWS_RST;
            cols_reg     <= COLS_RST;
            in_col_reg   <= '0;
            v1_reg       <= 1'b0;
            pending_reg  <= '0;
            emit_row_reg <= '0;
            emit_col_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
            if (restart) begin
                in_col_reg   <= '0;
                v1_reg       <= 1'b0;
                pending_reg  <= '0;
                emit_row_reg <= '0;
                emit_col_reg <= '0;
                m_valid_reg  <= 1'b0;
            end else begin
                in_col_reg   <= in_col_next;
                v1_reg       <= v1_next;
                pending_reg  <= pending_next;
                emit_row_reg <= emit_row_next;
                emit_col_reg <= emit_col_next;
                m_valid_reg  <= m_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind1_reg <= s_tuser;
            cell1_reg <= s_tdata[0];
            col1_reg  <= in_col_reg;
        end
        m_alive_reg <= m_alive_next;
        m_row_reg   <= m_row_next;
        m_col_reg   <= m_col_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_col_reg, m_row_reg, m_alive_reg};
    assign m_tlast  = m_last_reg;

    `LGS_ASSERT_IMPL(a_pending_bound, aclk, aresetn, 1'b1, pending_reg <= cols_plus1)
    `LGS_ASSERT_IMPL(a_col_range, aclk, aresetn, 1'b1, (DIMC_W'(in_col_reg) < cols_reg) && (DIMC_W'(emit_col_reg) < cols_reg))
    `LGS_ASSERT_NEXT(a_border_dead, aclk, aresetn, emit && !restart && (emit_col_reg == '0), m_valid_reg && !m_alive_reg)
    `LGS_ASSERT_NEXT(a_accept_loads, aclk, aresetn, accept && !restart, v1_reg)

endmodule
